// ----- rtl/frbc_pkg.sv -----
// ----------------------------------------------------------------------------
// frbc_pkg
// Shared types, constants and helpers for the FASTA record base counter.
// ----------------------------------------------------------------------------
package frbc_pkg;

  // Internal counter width (16 to 64); outputs are clamped to 32 bits.
  localparam int COUNT_WIDTH = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_FILE   = 2'd2
  } kind_t;

  localparam logic [7:0] CHAR_GT  = 8'h3E;
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_UC  = 8'h43;
  localparam logic [7:0] CHAR_LC  = 8'h63;
  localparam logic [7:0] CHAR_UG  = 8'h47;
  localparam logic [7:0] CHAR_LG  = 8'h67;
  localparam logic [7:0] CHAR_UT  = 8'h54;
  localparam logic [7:0] CHAR_LT  = 8'h74;

  localparam logic [2:0] SYM_A     = 3'd0;
  localparam logic [2:0] SYM_C     = 3'd1;
  localparam logic [2:0] SYM_G     = 3'd2;
  localparam logic [2:0] SYM_T     = 3'd3;
  localparam logic [2:0] SYM_OTHER = 3'd4;
  localparam int         NUM_SYMS  = 5;

  localparam logic [15:0] INDEX_MAX = 16'hFFFF;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id_char;
    logic [15:0] record_number;
    logic [31:0] id_length;
    logic [31:0] count_a;
    logic [31:0] count_c;
    logic [31:0] count_g;
    logic [31:0] count_t;
    logic [31:0] count_other;
    logic [31:0] symbol_total;
    logic [31:0] line_total;
    logic        last;
  } result_t;

  // Results produced by one accepted byte, handed to the queue.
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [31:0] out32(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [2:0] sym_class(logic [7:0] b);
    logic [2:0] k;
    case (b)
      CHAR_UA, CHAR_LA: k = SYM_A;
      CHAR_UC, CHAR_LC: k = SYM_C;
      CHAR_UG, CHAR_LG: k = SYM_G;
      CHAR_UT, CHAR_LT: k = SYM_T;
      default:          k = SYM_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/fasta_record_base_counter.sv -----
// ----------------------------------------------------------------------------
// fasta_record_base_counter
// FASTA parser: echoes header bytes and reports per-record base composition.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while in_stall is low. The parser state is
// updated in the cycle the byte is accepted and its results (none, one, or two
// on an end-of-input mark while a record is open) go into a four-entry result
// queue, which hands out one result per cycle while out_stall is low.
// in_stall rises only while the queue holds more than two results, i.e. when
// the output side has been stalled. With an empty queue the first result of a
// byte is on the output in the cycle after the byte is accepted, and a second
// follows once the first is taken. End of input resets all parser state.
module fasta_record_base_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  id_char,
  output logic [15:0] record_number,
  output logic [31:0] id_length,
  output logic [31:0] count_a,
  output logic [31:0] count_c,
  output logic [31:0] count_g,
  output logic [31:0] count_t,
  output logic [31:0] count_other,
  output logic [31:0] symbol_total,
  output logic [31:0] line_total,
  output logic        last_result
);

  frbc_pkg::push_t   push;
  frbc_pkg::result_t head_res;
  logic              room;
  logic              fire;

  assign in_stall = !room;
  assign fire     = in_valid && room;

  frbc_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .push         (push)
  );

  frbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_res  (head_res)
  );

  assign result_kind   = 2'(head_res.kind);
  assign id_char       = head_res.id_char;
  assign record_number = head_res.record_number;
  assign id_length     = head_res.id_length;
  assign count_a       = head_res.count_a;
  assign count_c       = head_res.count_c;
  assign count_g       = head_res.count_g;
  assign count_t       = head_res.count_t;
  assign count_other   = head_res.count_other;
  assign symbol_total  = head_res.symbol_total;
  assign line_total    = head_res.line_total;
  assign last_result   = head_res.last;

endmodule

// ----- rtl/frbc_parse.sv -----
// ----------------------------------------------------------------------------
// frbc_parse
// Parser state and per-byte decode; builds up to two results per byte.
// ----------------------------------------------------------------------------
module frbc_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  output frbc_pkg::push_t     push
);

  logic                 in_header, in_header_next;
  logic                 at_line_start, at_line_start_next;
  logic                 record_open, record_open_next;
  logic [15:0]          record_index, record_index_next;
  frbc_pkg::cnt_t       header_length, header_length_next;
  frbc_pkg::cnt_t       symbol_counts [frbc_pkg::NUM_SYMS];
  frbc_pkg::cnt_t       symbol_counts_next [frbc_pkg::NUM_SYMS];
  frbc_pkg::cnt_t       sequence_total, sequence_total_next;
  frbc_pkg::cnt_t       newline_count, newline_count_next;

  frbc_pkg::result_t    rec_res;
  frbc_pkg::result_t    file_res;
  frbc_pkg::result_t    char_res;
  logic [2:0]           sym;

  assign sym = frbc_pkg::sym_class(in_byte);

  always_comb begin
    rec_res               = '0;
    rec_res.kind          = frbc_pkg::KIND_RECORD;
    rec_res.record_number = record_index;
    rec_res.id_length     = frbc_pkg::out32(header_length);
    rec_res.count_a       = frbc_pkg::out32(symbol_counts[frbc_pkg::SYM_A]);
    rec_res.count_c       = frbc_pkg::out32(symbol_counts[frbc_pkg::SYM_C]);
    rec_res.count_g       = frbc_pkg::out32(symbol_counts[frbc_pkg::SYM_G]);
    rec_res.count_t       = frbc_pkg::out32(symbol_counts[frbc_pkg::SYM_T]);
    rec_res.count_other   = frbc_pkg::out32(symbol_counts[frbc_pkg::SYM_OTHER]);
    rec_res.symbol_total  = frbc_pkg::out32(sequence_total);

    file_res            = '0;
    file_res.kind       = frbc_pkg::KIND_FILE;
    file_res.line_total = frbc_pkg::out32(newline_count);
    file_res.last       = 1'b1;
    if (record_open) begin
      file_res.record_number = (record_index == frbc_pkg::INDEX_MAX) ?
                               frbc_pkg::INDEX_MAX : record_index + 16'd1;
    end

    char_res               = '0;
    char_res.kind          = frbc_pkg::KIND_CHAR;
    char_res.id_char       = in_byte;
    char_res.record_number = record_index;
    char_res.last          = 1'b1;
  end

  always_comb begin
    in_header_next      = in_header;
    at_line_start_next  = at_line_start;
    record_open_next    = record_open;
    record_index_next   = record_index;
    header_length_next  = header_length;
    sequence_total_next = sequence_total;
    newline_count_next  = newline_count;
    for (int i = 0; i < frbc_pkg::NUM_SYMS; i++) begin
      symbol_counts_next[i] = symbol_counts[i];
    end
    push      = '0;
    push.res0 = rec_res;
    push.res1 = file_res;

    if (end_of_input) begin
      // open record summary first, then the file summary; state back to reset
      if (record_open) begin
        push.num = 2'd2;
      end else begin
        push.num  = 2'd1;
        push.res0 = file_res;
      end
      in_header_next      = 1'b0;
      at_line_start_next  = 1'b1;
      record_open_next    = 1'b0;
      record_index_next   = '0;
      header_length_next  = '0;
      sequence_total_next = '0;
      newline_count_next  = '0;
      for (int i = 0; i < frbc_pkg::NUM_SYMS; i++) begin
        symbol_counts_next[i] = '0;
      end
    end else if (in_byte == frbc_pkg::CHAR_NL) begin
      in_header_next     = 1'b0;
      at_line_start_next = 1'b1;
      newline_count_next = frbc_pkg::sat_inc(newline_count);
    end else if (in_byte == frbc_pkg::CHAR_GT) begin
      // '>' only opens a record at line start; elsewhere it is dropped
      if (at_line_start) begin
        if (record_open) begin
          push.num       = 2'd1;
          push.res0.last = 1'b1;
          if (record_index != frbc_pkg::INDEX_MAX) begin
            record_index_next = record_index + 16'd1;
          end
        end
        record_open_next    = 1'b1;
        in_header_next      = 1'b1;
        header_length_next  = '0;
        sequence_total_next = '0;
        for (int i = 0; i < frbc_pkg::NUM_SYMS; i++) begin
          symbol_counts_next[i] = '0;
        end
      end
      at_line_start_next = 1'b0;
    end else if (in_header) begin
      at_line_start_next = 1'b0;
      header_length_next = frbc_pkg::sat_inc(header_length);
      push.num           = 2'd1;
      push.res0          = char_res;
    end else begin
      at_line_start_next = 1'b0;
      if (record_open) begin
        for (int i = 0; i < frbc_pkg::NUM_SYMS; i++) begin
          if (sym == 3'(i)) begin
            symbol_counts_next[i] = frbc_pkg::sat_inc(symbol_counts[i]);
          end
        end
        sequence_total_next = frbc_pkg::sat_inc(sequence_total);
      end
    end

    if (!fire) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header      <= 1'b0;
      at_line_start  <= 1'b1;
      record_open    <= 1'b0;
      record_index   <= '0;
      header_length  <= '0;
      sequence_total <= '0;
      newline_count  <= '0;
      for (int i = 0; i < frbc_pkg::NUM_SYMS; i++) begin
        symbol_counts[i] <= '0;
      end
    end else if (fire) begin
      in_header      <= in_header_next;
      at_line_start  <= at_line_start_next;
      record_open    <= record_open_next;
      record_index   <= record_index_next;
      header_length  <= header_length_next;
      sequence_total <= sequence_total_next;
      newline_count  <= newline_count_next;
      for (int i = 0; i < frbc_pkg::NUM_SYMS; i++) begin
        symbol_counts[i] <= symbol_counts_next[i];
      end
    end
  end

endmodule

// ----- rtl/frbc_queue.sv -----
// ----------------------------------------------------------------------------
// frbc_queue
// Result queue: up to two results in a cycle, one out a cycle if unstalled.
// ----------------------------------------------------------------------------
module frbc_queue (
  input  logic              clk,
  input  logic              rst,
  input  frbc_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output frbc_pkg::result_t head_res
);

  frbc_pkg::result_t                 mem [frbc_pkg::QUEUE_DEPTH];
  logic [frbc_pkg::QUEUE_AW-1:0]     rd_ptr, wr_ptr;
  logic [frbc_pkg::QUEUE_CW-1:0]     fill, fill_next;
  logic                              pop;

  assign out_valid = (fill != '0);
  assign pop       = out_valid && !out_stall;
  assign head_res  = mem[rd_ptr];
  // an accepted byte may bring two results, so keep two free slots
  assign room      = (fill <= frbc_pkg::QUEUE_CW'(frbc_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    fill_next = fill + frbc_pkg::QUEUE_CW'(push.num);
    if (pop) begin
      fill_next = fill_next - frbc_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      fill   <= fill_next;
      wr_ptr <= wr_ptr + frbc_pkg::QUEUE_AW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + frbc_pkg::QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + frbc_pkg::QUEUE_AW'(1)] <= push.res1;
    end
  end

endmodule

// ----- tb/fasta_record_base_counter_test.sv -----
// ----------------------------------------------------------------------------
// fasta_record_base_counter_test
// Feeds FASTA text byte by byte, with directed corner cases, a run of empty
// records sent back to back and random well-formed and broken streams. Results
// are predicted per byte and checked in order against the output transactions.
// ----------------------------------------------------------------------------
module fasta_record_base_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import frbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned BURST_RECORDS = 12;
  localparam int unsigned RANDOM_ITEMS = 700;

  typedef struct {
    logic [7:0] data;
    logic       eoi;
    logic       pause;
    logic       burst;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  id_char;
  logic [15:0] record_number;
  logic [31:0] id_length;
  logic [31:0] count_a;
  logic [31:0] count_c;
  logic [31:0] count_g;
  logic [31:0] count_t;
  logic [31:0] count_other;
  logic [31:0] symbol_total;
  logic [31:0] line_total;
  logic        last_result;

  // parser shadow state
  logic        hdr_open;
  logic        line_start;
  logic        rec_open;
  logic [15:0] rec_idx;
  cnt_t        hdr_len;
  cnt_t        base_cnt [NUM_SYMS];
  cnt_t        seq_len;
  cnt_t        nl_total;

  feed_t       byte_stream [$];
  result_t     awaited [$];
  feed_t       cur;
  result_t     seen;
  result_t     want;
  logic        quiet = 1'b0;
  logic        held_once = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned reports_seen = 0;
  int unsigned faults = 0;
  int unsigned cycles = 0;

  fasta_record_base_counter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .id_char      (id_char),
    .record_number(record_number),
    .id_length    (id_length),
    .count_a      (count_a),
    .count_c      (count_c),
    .count_g      (count_g),
    .count_t      (count_t),
    .count_other  (count_other),
    .symbol_total (symbol_total),
    .line_total   (line_total),
    .last_result  (last_result)
  );

  always #5ns clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fasta_record_base_counter_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic cnt_t bump(cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] clamp32(cnt_t v);
    if (COUNT_WIDTH > 32 && (v >> 32) != 0) return '1;
    return 32'(v);
  endfunction

  function automatic result_t record_report();
    result_t r;
    r = '0;
    r.kind          = KIND_RECORD;
    r.record_number = rec_idx;
    r.id_length     = clamp32(hdr_len);
    r.count_a       = clamp32(base_cnt[SYM_A]);
    r.count_c       = clamp32(base_cnt[SYM_C]);
    r.count_g       = clamp32(base_cnt[SYM_G]);
    r.count_t       = clamp32(base_cnt[SYM_T]);
    r.count_other   = clamp32(base_cnt[SYM_OTHER]);
    r.symbol_total  = clamp32(seq_len);
    return r;
  endfunction

  task automatic clear_parser();
    hdr_open   = 1'b0;
    line_start = 1'b1;
    rec_open   = 1'b0;
    rec_idx    = '0;
    hdr_len    = '0;
    seq_len    = '0;
    nl_total   = '0;
    foreach (base_cnt[i]) base_cnt[i] = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eoi);
    result_t r;
    logic [2:0] k;
    if (eoi) begin
      if (rec_open) awaited.push_back(record_report());
      r = '0;
      r.kind = KIND_FILE;
      if (rec_open) r.record_number = (rec_idx == INDEX_MAX) ? INDEX_MAX : rec_idx + 1'b1;
      r.line_total = clamp32(nl_total);
      r.last = 1'b1;
      awaited.push_back(r);
      clear_parser();
    end else if (b == CHAR_NL) begin
      hdr_open   = 1'b0;
      line_start = 1'b1;
      nl_total   = bump(nl_total);
    end else if (b == CHAR_GT) begin
      // only a '>' at line start opens a record; elsewhere it is dropped
      if (line_start) begin
        if (rec_open) begin
          r = record_report();
          r.last = 1'b1;
          awaited.push_back(r);
          if (rec_idx != INDEX_MAX) rec_idx = rec_idx + 1'b1;
        end
        rec_open = 1'b1;
        hdr_open = 1'b1;
        hdr_len  = '0;
        seq_len  = '0;
        foreach (base_cnt[i]) base_cnt[i] = '0;
      end
      line_start = 1'b0;
    end else if (hdr_open) begin
      line_start = 1'b0;
      hdr_len = bump(hdr_len);
      r = '0;
      r.kind          = KIND_CHAR;
      r.id_char       = b;
      r.record_number = rec_idx;
      r.last          = 1'b1;
      awaited.push_back(r);
    end else begin
      line_start = 1'b0;
      if (rec_open) begin
        case (b)
          CHAR_UA, CHAR_LA: k = SYM_A;
          CHAR_UC, CHAR_LC: k = SYM_C;
          CHAR_UG, CHAR_LG: k = SYM_G;
          CHAR_UT, CHAR_LT: k = SYM_T;
          default:          k = SYM_OTHER;
        endcase
        base_cnt[k] = bump(base_cnt[k]);
        seq_len = bump(seq_len);
      end
    end
  endtask

  // mostly short gaps, a few long ones; none at all while calm
  function automatic int unsigned draw_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string describe(result_t r);
    return {$sformatf("kind=%0d chr=%02h rec=%0d idlen=%0d ",
                      r.kind, r.id_char, r.record_number, r.id_length),
            $sformatf("acgt=%0d/%0d/%0d/%0d oth=%0d tot=%0d lines=%0d last=%0b",
                      r.count_a, r.count_c, r.count_g, r.count_t, r.count_other,
                      r.symbol_total, r.line_total, r.last)};
  endfunction

  // ------------------------------------------------------------------ driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      in_byte      <= '0;
      end_of_input <= 1'b0;
      gap_left      = 0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(cur.data, cur.eoi);
        gap_left = draw_gap(cur.burst || cycles[8]);
      end
      // a stalled transaction keeps its payload
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0 && byte_stream[0].pause) begin
          in_valid <= 1'b0;
          if (awaited.size() == 0) void'(byte_stream.pop_front());
        end else if (byte_stream.size() != 0) begin
          cur = byte_stream.pop_front();
          in_valid     <= 1'b1;
          in_byte      <= cur.data;
          end_of_input <= cur.eoi;
          quiet        <= cur.burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.kind          = kind_t'(result_kind);
        seen.id_char       = id_char;
        seen.record_number = record_number;
        seen.id_length     = id_length;
        seen.count_a       = count_a;
        seen.count_c       = count_c;
        seen.count_g       = count_g;
        seen.count_t       = count_t;
        seen.count_other   = count_other;
        seen.symbol_total  = symbol_total;
        seen.line_total    = line_total;
        seen.last          = last_result;
        reports_seen++;
        if (awaited.size() == 0) begin
          faults++;
          if (faults <= 10) $display("%0t: unexpected result %s", $time, describe(seen));
        end else begin
          want = awaited.pop_front();
          if (seen !== want) begin
            faults++;
            if (faults <= 10) begin
              $display("%0t: result %0d differs", $time, reports_seen);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      // one long hold-off so the result queue fills and the input stalls
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && reports_seen >= 25) begin
        held_once = 1'b1;
        hold_left = 299;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0) stall_left = draw_gap(quiet || cycles[8]);
        if (stall_left != 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] b, input logic burst = 1'b0);
    byte_stream.push_back('{data: b, eoi: 1'b0, pause: 1'b0, burst: burst});
  endtask

  task automatic push_end(input logic [7:0] b);
    byte_stream.push_back('{data: b, eoi: 1'b1, pause: 1'b0, burst: 1'b0});
  endtask

  task automatic push_pause();
    byte_stream.push_back('{data: 8'h00, eoi: 1'b0, pause: 1'b1, burst: 1'b0});
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 7))
      0: return CHAR_UA;
      1: return CHAR_LA;
      2: return CHAR_UC;
      3: return CHAR_LC;
      4: return CHAR_UG;
      5: return CHAR_LG;
      6: return CHAR_UT;
      default: return CHAR_LT;
    endcase
  endfunction

  function automatic logic [7:0] seq_byte(input logic stray_gt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) return pick_base();
    if (r < 82) return 8'($urandom);
    if (r < 90) return "N";
    if (stray_gt && r < 95) return CHAR_GT;
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] hdr_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom);
  endfunction

  // one stream up to its end mark: mostly well formed, some noise or truncated
  task automatic add_stream();
    int unsigned style, n_rec, n_lines;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 20)) push_byte(8'($urandom));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) push_byte(seq_byte(1'b1));
        push_byte(CHAR_NL);
      end
      n_rec = $urandom_range(0, 5);
      for (int unsigned i = 0; i < n_rec; i++) begin
        push_byte(CHAR_GT);
        repeat ($urandom_range(0, 10)) push_byte(hdr_byte());
        if (!(style == 1 && i == n_rec - 1)) begin
          push_byte(CHAR_NL);
          n_lines = $urandom_range(0, 3);
          repeat (n_lines) begin
            repeat ($urandom_range(0, 20)) push_byte(seq_byte(style == 2));
            push_byte(CHAR_NL);
          end
        end
      end
    end
    push_end(8'($urandom));
  endtask

  initial begin
    int unsigned base;

    // directed: stray text before the first header, a '>' after it not at
    // line start, header edge bytes, every base in both cases, mid-line '>'
    push_byte("x");
    push_byte(CHAR_GT);
    push_byte(CHAR_NL);
    push_byte(CHAR_GT);
    push_byte("h");
    push_byte(CHAR_GT);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_NL);
    push_byte(CHAR_UA);
    push_byte(CHAR_LA);
    push_byte(CHAR_UC);
    push_byte(CHAR_LC);
    push_byte(CHAR_UG);
    push_byte(CHAR_LG);
    push_byte(CHAR_UT);
    push_byte(CHAR_LT);
    push_byte("N");
    push_byte(CHAR_GT);
    push_byte(CHAR_NL);
    push_byte(CHAR_GT);
    push_byte("q");
    push_end(8'hA5);   // open header without newline at end
    push_end(8'h5A);   // empty stream
    push_pause();

    // empty records back to back, then one with a header and a base
    for (int unsigned i = 0; i < BURST_RECORDS; i++) begin
      push_byte(CHAR_GT, 1'b1);
      push_byte(CHAR_NL, 1'b1);
    end
    push_byte(CHAR_GT);
    push_byte("z");
    push_byte(CHAR_NL);
    push_byte(CHAR_UG);
    push_end(8'hFF);
    push_pause();

    base = byte_stream.size();
    while (byte_stream.size() - base < RANDOM_ITEMS) begin
      add_stream();
      if ($urandom_range(0, 7) == 0) push_pause();
    end

    while (byte_stream.size() != 0 || in_valid) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (faults == 0) begin
      $display("fasta_record_base_counter_test: PASS");
    end else begin
      $display("fasta_record_base_counter_test: FAIL");
    end
    $finish;
  end

endmodule
